[src/avgp_pkg.sv]
// Shared types and constants for the average-predictor residual codec.
package avgp_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 4096;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned CHAN_W        = 9;
  localparam int unsigned PIX_W         = 24;
  localparam int unsigned PADDR_W       = 4;
  localparam int unsigned PDATA_W       = 32;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_t;

endpackage

[src/avgp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module avgp_ram #(
  parameter int unsigned WIDTH = avgp_pkg::PIX_W,
  parameter int unsigned DEPTH = avgp_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/average_predictor_residual_codec.sv]
// Average-predictor DPCM codec: raster BGR pixels to residuals and back.
//
//   channel | direction | ports                                   | handshake
//   in      | request   | in_blue, in_green, in_red               | in_valid / in_stall
//   out     | result    | out_blue, out_green, out_red, out_frame_last | out_valid / out_stall
//   cfg     | APB rd/wr | paddr, pwdata, prdata                   | psel, penable, pwrite, pready
//
// One pixel per clock while out is not stalled: an accepted request is held in the input
// register, the predictor and add/subtract run combinationally from it, and the result
// lands in the output register, which drives out_valid and the result ports.
// The previous row lives in a RAM read one pixel ahead, with a one-entry bypass
// for a same-column write. Reset is synchronous; the row store is not cleared.
// A stall on out holds the output register and backs up into in_stall.
module average_predictor_residual_codec #(
  parameter int unsigned MAX_WIDTH = avgp_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [avgp_pkg::CHAN_W-1:0] in_blue,
  input  logic signed [avgp_pkg::CHAN_W-1:0] in_green,
  input  logic signed [avgp_pkg::CHAN_W-1:0] in_red,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [avgp_pkg::CHAN_W-1:0] out_blue,
  output logic signed [avgp_pkg::CHAN_W-1:0] out_green,
  output logic signed [avgp_pkg::CHAN_W-1:0] out_red,
  output logic                           out_frame_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [avgp_pkg::PADDR_W-1:0]   paddr,
  input  logic [avgp_pkg::PDATA_W-1:0]   pwdata,
  output logic [avgp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  import avgp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  // configuration
  logic             dir_r;
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  // pipeline
  logic              s1_valid_r;
  logic [CHAN_W-1:0] s1_chan_r [3];
  logic              out_valid_r;
  logic [CHAN_W-1:0] out_chan_r [3];
  logic              out_last_r;

  // frame state
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  pixel_t           left_r;
  logic             byp_r;
  pixel_t           byp_px_r;

  logic             in_fire, s1_fire, out_free;
  logic [EW-1:0]    eff_w, width_x, col_x, col_nxt_x;
  logic [CFG_W-1:0] eff_h, row_x;
  logic [CW-1:0]    col_c, rd_addr;
  logic [ROW_W-1:0] row_c;
  logic             row_end, frame_end;
  logic             first_col, first_row;
  pixel_t           top_px, ram_rdata, pixel;
  logic [CHAN_W-1:0] res_chan [3];

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= 1'b0;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIRECTION: dir_r    <= pwdata[0];
        REG_WIDTH:     width_r  <= pwdata[CFG_W-1:0];
        REG_HEIGHT:    height_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DIRECTION: prdata = PDATA_W'(dir_r);
      REG_WIDTH:     prdata = PDATA_W'(width_r);
      REG_HEIGHT:    prdata = PDATA_W'(height_r);
      default:       prdata = '0;
    endcase
  end

  // effective frame size: zero means one, saturate at the store depth / height limit
  assign width_x = EW'(width_r);
  assign eff_w = (width_r == '0) ? EW'(1) :
                 (width_x > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : width_x;
  assign eff_h = (height_r == '0) ? CFG_W'(1) :
                 (height_r > CFG_W'(HEIGHT_LIMIT)) ? CFG_W'(HEIGHT_LIMIT) : height_r;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // position of the pixel in the input register
  assign col_x = EW'(col_r);
  assign row_x = CFG_W'(row_r);
  assign col_c = (col_x >= eff_w) ? CW'(eff_w - EW'(1)) : col_r;
  assign row_c = (row_x >= eff_h) ? ROW_W'(eff_h - CFG_W'(1)) : row_r;
  assign row_end   = (EW'(col_x + EW'(1)) >= eff_w);
  assign frame_end = row_end && (CFG_W'(row_x + CFG_W'(1)) >= eff_h);
  assign first_col = (col_c == '0);
  assign first_row = (row_c == '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (s1_fire) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = ROW_W'(row_c + ROW_W'(1));
      end else begin
        col_nxt = CW'(col_c + CW'(1));
      end
    end
  end

  // prefetch the top pixel for whatever sits in the input register next cycle
  assign col_nxt_x = EW'(col_nxt);
  assign rd_addr   = (col_nxt_x >= eff_w) ? CW'(eff_w - EW'(1)) : col_nxt;
  assign top_px    = byp_r ? byp_px_r : ram_rdata;

  avgp_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_ram (
    .clk  (clk),
    .we   (s1_fire),
    .waddr(col_c),
    .wdata(pixel),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    logic [7:0] lft, abv, pred, val, fld;
    pixel = '0;
    for (int k = 0; k < 3; k++) begin
      lft = left_r[8*k +: 8];
      abv = top_px[8*k +: 8];
      fld = s1_chan_r[k][7:0];
      if (first_col && first_row) begin
        pred = '0;
      end else if (first_row) begin
        pred = lft;
      end else if (first_col) begin
        pred = abv;
      end else begin
        pred = 8'(({1'b0, lft} + {1'b0, abv}) >> 1);
      end
      if (!dir_r) begin
        val         = fld;
        res_chan[k] = {1'b0, val} - {1'b0, pred};
      end else begin
        // sum wraps mod 256, so only the low residual byte matters
        val         = pred + fld;
        res_chan[k] = {1'b0, val};
      end
      pixel[8*k +: 8] = val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      byp_r       <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        left_r      <= pixel;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      byp_r <= s1_fire && (col_c == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_chan_r[0] <= in_blue;
      s1_chan_r[1] <= in_green;
      s1_chan_r[2] <= in_red;
    end
    if (s1_fire) begin
      out_chan_r <= res_chan;
      out_last_r <= frame_end;
    end
    byp_px_r <= pixel;
  end

  assign out_valid      = out_valid_r;
  assign out_blue       = out_chan_r[0];
  assign out_green      = out_chan_r[1];
  assign out_red        = out_chan_r[2];
  assign out_frame_last = out_last_r;

endmodule

[src/avgp_checker.sv]
// Port-level checks for the codec, bound to the top level.
module avgp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [avgp_pkg::CHAN_W-1:0]    out_blue,
  input logic [avgp_pkg::CHAN_W-1:0]    out_green,
  input logic [avgp_pkg::CHAN_W-1:0]    out_red,
  input logic                           out_frame_last,
  input logic                           pready
);

  import avgp_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_blue) && $stable(out_green) &&
                               $stable(out_red) && $stable(out_frame_last))
    else $error("stalled result changed");

  // input backs up only behind a stalled, full output
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind average_predictor_residual_codec avgp_checker u_avgp_checker (.*);

[tb/average_predictor_residual_codec_tb.sv]
// Self-checking testbench for the average-predictor residual codec.

typedef struct packed {
  logic signed [8:0] blue;
  logic signed [8:0] green;
  logic signed [8:0] red;
  logic              last;
} pixel_result_t;

class dpcm_tracker;
  logic                  decode;
  logic [12:0]           width_reg;
  logic [12:0]           height_reg;
  avgp_pkg::pixel_t      row_above [avgp_pkg::DEF_MAX_WIDTH];
  avgp_pkg::pixel_t      left_px;
  int unsigned           col_q;
  int unsigned           row_q;
  int unsigned           written_cols;
  pixel_result_t         expected_q[$];
  int unsigned           mismatches;
  int unsigned           checked;
  int unsigned           frames;

  function new();
    decode = 1'b0;
    width_reg = avgp_pkg::RST_WIDTH;
    height_reg = avgp_pkg::RST_HEIGHT;
    foreach (row_above[i]) row_above[i] = '0;
    left_px = '0;
    col_q = 0;
    row_q = 0;
    written_cols = 0;
    mismatches = 0;
    checked = 0;
    frames = 0;
  endfunction

  function void write_register(avgp_pkg::reg_idx_t idx, logic [31:0] value);
    case (idx)
      avgp_pkg::REG_DIRECTION: decode = value[0];
      avgp_pkg::REG_WIDTH:     width_reg = value[12:0];
      avgp_pkg::REG_HEIGHT:    height_reg = value[12:0];
      default: ;
    endcase
  endfunction

  function int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > avgp_pkg::DEF_MAX_WIDTH) return avgp_pkg::DEF_MAX_WIDTH;
    return width_reg;
  endfunction

  function int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > avgp_pkg::HEIGHT_LIMIT) return avgp_pkg::HEIGHT_LIMIT;
    return height_reg;
  endfunction

  // Predict the result of one accepted request and advance the raster position.
  function void take_pixel(logic [8:0] b, logic [8:0] g, logic [8:0] r);
    logic [8:0]       fld [3];
    logic [8:0]       res [3];
    logic [7:0]       lft, abv, pred, val;
    avgp_pkg::pixel_t above, px;
    int unsigned      w, h, c, rw;
    logic             row_end, frame_end;
    pixel_result_t    e;
    fld[0] = b;
    fld[1] = g;
    fld[2] = r;
    w = active_width();
    h = active_height();
    c = (col_q >= w) ? w - 1 : col_q;
    rw = (row_q >= h) ? h - 1 : row_q;
    above = row_above[c];
    px = '0;
    for (int k = 0; k < 3; k++) begin
      lft = left_px[8*k +: 8];
      abv = above[8*k +: 8];
      if (c == 0 && rw == 0) pred = 8'd0;
      else if (rw == 0) pred = lft;
      else if (c == 0) pred = abv;
      else pred = 8'(({1'b0, lft} + {1'b0, abv}) >> 1);
      if (!decode) begin
        val = fld[k][7:0];
        res[k] = {1'b0, val} - {1'b0, pred};
      end else begin
        val = pred + fld[k][7:0];
        res[k] = {1'b0, val};
      end
      px[8*k +: 8] = val;
    end
    row_above[c] = px;
    left_px = px;
    if (c + 1 > written_cols) written_cols = c + 1;
    row_end = (col_q + 1 >= w);
    frame_end = row_end && (row_q + 1 >= h);
    e.blue = res[0];
    e.green = res[1];
    e.red = res[2];
    e.last = frame_end;
    expected_q.push_back(e);
    if (frame_end) begin
      col_q = 0;
      row_q = 0;
    end else if (row_end) begin
      col_q = 0;
      row_q = rw + 1;
    end else begin
      col_q = c + 1;
    end
  endfunction

  function void check_output(logic signed [8:0] b, logic signed [8:0] g,
                             logic signed [8:0] r, logic last);
    pixel_result_t e;
    if (expected_q.size() == 0) begin
      $error("result with no request pending: blue %0d green %0d red %0d", b, g, r);
      mismatches++;
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (e.last) frames++;
    if (b !== e.blue) begin
      $error("out_blue: expected %0d, got %0d", e.blue, b);
      mismatches++;
    end
    if (g !== e.green) begin
      $error("out_green: expected %0d, got %0d", e.green, g);
      mismatches++;
    end
    if (r !== e.red) begin
      $error("out_red: expected %0d, got %0d", e.red, r);
      mismatches++;
    end
    if (last !== e.last) begin
      $error("out_frame_last: expected %0b, got %0b", e.last, last);
      mismatches++;
    end
  endfunction
endclass

module average_predictor_residual_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import avgp_pkg::*;

  localparam int unsigned PIXEL_TARGET = 500;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [CHAN_W-1:0] in_blue = '0;
  logic signed [CHAN_W-1:0] in_green = '0;
  logic signed [CHAN_W-1:0] in_red = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [CHAN_W-1:0] out_blue;
  logic signed [CHAN_W-1:0] out_green;
  logic signed [CHAN_W-1:0] out_red;
  logic                     out_frame_last;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  dpcm_tracker tracker = new();
  int unsigned sent = 0;
  int unsigned settings = 0;
  int unsigned cfg_failures = 0;
  int unsigned calm_items = 0;

  average_predictor_residual_codec dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_output(out_blue, out_green, out_red, out_frame_last);
  end

  initial begin : result_stall
    int unsigned hold, calm;
    hold = 0;
    calm = 0;
    forever begin
      @(negedge clk);
      if (calm > 0) begin
        calm--;
        out_stall = 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
        case ($urandom_range(0, 9))
          0, 1, 2: hold = idle_len();
          3: calm = $urandom_range(20, 80);
          default: ;
        endcase
      end
    end
  end

  task automatic pause_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic send_pixel(logic [8:0] b, logic [8:0] g, logic [8:0] r);
    @(negedge clk);
    in_valid = 1'b1;
    in_blue = b;
    in_green = g;
    in_red = r;
    do @(posedge clk); while (in_stall);
    tracker.take_pixel(b, g, r);
    sent++;
    if (calm_items > 0) calm_items--;
    else if ($urandom_range(0, 3) == 0) pause_sender(idle_len());
    else if ($urandom_range(0, 30) == 0) calm_items = $urandom_range(15, 50);
  endtask

  // Hold off requests until every pending result is out.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    logic [31:0] stored;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_register(idx, value);
    settings++;
    // read back in a second transfer
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    stored = (idx == REG_DIRECTION) ? (value & 32'h1) : (value & 32'h1FFF);
    if (prdata !== stored) begin
      $error("prdata of %s: expected %0d, got %0d", idx.name(), stored, prdata);
      cfg_failures++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [8:0] field_value();
    if (!tracker.decode) begin
      if ($urandom_range(0, 15) == 0) return 9'($urandom_range(0, 511));
      return 9'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 1) == 0) return 9'($urandom_range(0, 32) - 16);
    return 9'($urandom_range(0, 511));
  endfunction

  task automatic random_phase(int unsigned items);
    int unsigned w, h, r;
    drain();
    r = $urandom_range(0, 99);
    if (r < 60) w = $urandom_range(1, 8);
    else if (r < 90) w = $urandom_range(9, 40);
    else w = $urandom_range(41, 200);
    // keep every top-row read on a column already written
    if (tracker.row_q != 0 && w > tracker.written_cols) w = tracker.written_cols;
    h = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
    write_reg(REG_DIRECTION, 32'($urandom_range(0, 1)));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    repeat (items) send_pixel(field_value(), field_value(), field_value());
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: encode, first row of a wide frame, out-of-range samples
    send_pixel(9'd0, 9'd255, 9'h100);
    send_pixel(9'd255, 9'd0, 9'h1FF);
    send_pixel(9'd128, 9'd127, 9'd1);

    // shrink the frame while the column counter is past the new width
    drain();
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd2);
    send_pixel(9'd255, 9'd0, 9'd254);
    send_pixel(9'd0, 9'd255, 9'd1);
    send_pixel(9'd255, 9'd255, 9'd0);
    send_pixel(9'd0, 9'd0, 9'd255);
    send_pixel(9'd255, 9'd1, 9'd128);
    send_pixel(9'd0, 9'd254, 9'd3);

    // decode with extreme residuals, wrapping both ways
    drain();
    write_reg(REG_DIRECTION, 32'd1);
    send_pixel(9'd255, 9'h101, 9'h100);
    send_pixel(9'h101, 9'd255, 9'd0);
    send_pixel(9'h100, 9'd1, 9'h1FF);
    send_pixel(9'd0, 9'h1FF, 9'd255);
    send_pixel(9'd1, 9'h100, 9'h101);
    send_pixel(9'h1FF, 9'd0, 9'd1);

    // zero width and height: every pixel is a whole frame
    drain();
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_HEIGHT, 32'd0);
    send_pixel(9'd17, 9'h1F0, 9'd255);
    send_pixel(9'd200, 9'd3, 9'h100);
    drain();
    write_reg(REG_DIRECTION, 32'd0);
    send_pixel(9'd255, 9'd0, 9'd77);
    send_pixel(9'h180, 9'd5, 9'd255);

    // oversize registers saturate
    drain();
    write_reg(REG_WIDTH, 32'h1FFF);
    write_reg(REG_HEIGHT, 32'h1FFF);
    send_pixel(9'd10, 9'd20, 9'd30);
    send_pixel(9'd255, 9'd0, 9'd31);
    send_pixel(9'd0, 9'd255, 9'd29);

    while (sent < PIXEL_TARGET) random_phase($urandom_range(20, 70));

    drain();
    repeat (10) @(posedge clk);
    if (tracker.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", tracker.expected_q.size());
      tracker.mismatches++;
    end
    $display("Sent %0d pixels over %0d register writes, encode and decode.", sent, settings);
    $display("Checked %0d results, %0d of them ending a frame.", tracker.checked,
             tracker.frames);
    if (tracker.mismatches == 0 && cfg_failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still pending", tracker.expected_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
